// ===== design/grs_pkg.sv =====
// Package for the group reverse stream block.
// Holds shared constants, register codes, the command and control structs
// and the back-end state type. No dependencies.
`default_nettype none

package grs_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_GROUP    = 16;
    localparam int DEF_SYMBOL_WIDTH = 8;

    // Fixed widths of the channel and register fields.
    localparam int SYM_W        = 8;
    localparam int GROUP_SIZE_W = 5;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 2;

    // Widest count and index over the supported range of MAX_GROUP (1 to 64).
    localparam int MAX_GROUP_LIMIT = 64;
    localparam int CNT_MAX_W       = $clog2(MAX_GROUP_LIMIT + 1);
    localparam int IDX_MAX_W       = $clog2(MAX_GROUP_LIMIT);

    // Depth of the command queue between front and back.
    localparam int CMD_DEPTH = 2;

    // Register map.
    localparam logic [APB_ADDR_W-1:0] ADDR_GROUP_SIZE = 2'd0;
    localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RESET = 5'd2;

    // One finished group handed from the front to the back.
    typedef struct packed {
        logic                 bank;
        logic [CNT_MAX_W-1:0] count;
        logic                 reverse;
        logic                 list_end;
    } t_cmd;

    // Buffer write control from the front.
    typedef struct packed {
        logic                 we;
        logic                 bank;
        logic [IDX_MAX_W-1:0] idx;
    } t_wr_ctl;

    // Bank handed back to the front once its last read has been issued.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

endpackage

`default_nettype wire

// ===== design/grs_if.sv =====
// Channel interfaces for the group reverse stream block.
// Depends on grs_pkg for the field widths.
`default_nettype none

interface grs_in_if
    import grs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             list_end;

    modport source (output valid, output symbol, output list_end, input ready);
    modport sink   (input valid, input symbol, input list_end, output ready);
endinterface

interface grs_out_if
    import grs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] out_symbol;
    logic             run_end;
    logic             list_done;

    modport source (output valid, output out_symbol, output run_end, output list_done,
                    input ready);
    modport sink   (input valid, input out_symbol, input run_end, input list_done,
                    output ready);
endinterface

`default_nettype wire

// ===== design/grs_front.sv =====
// Front end: accepts input words, writes them into the ping-pong buffer and
// issues one command per finished group. Depends on grs_pkg and grs_if.
`default_nettype none

module grs_front
    import grs_pkg::*;
#(
    parameter int MAX_GROUP    = DEF_MAX_GROUP,
    parameter int SYMBOL_WIDTH = DEF_SYMBOL_WIDTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [GROUP_SIZE_W-1:0] i_group_size,
    grs_in_if.sink                       i_in,
    input  wire logic                    i_cmd_full,
    output      logic                    o_cmd_push,
    output      t_cmd                    o_cmd,
    output      t_wr_ctl                 o_wr,
    output      logic [SYMBOL_WIDTH-1:0] o_wr_data,
    input  wire t_release                i_release
);

    localparam int CNT_W = $clog2(MAX_GROUP + 1);

    logic [CNT_W-1:0] r_fill;
    logic             r_bank;
    logic [1:0]       r_busy;

    logic [CNT_W-1:0] eff_size;
    logic [CNT_W-1:0] fill_inc;
    logic             accept;
    logic             full_group;
    logic             complete;

    // The group size is clamped to 1..MAX_GROUP.
    always_comb begin
        priority if (i_group_size == '0) begin
            eff_size = CNT_W'(1);
        end else if (int'(i_group_size) > MAX_GROUP) begin
            eff_size = CNT_W'(MAX_GROUP);
        end else begin
            eff_size = CNT_W'(i_group_size);
        end
    end

    assign i_in.ready = !r_busy[r_bank] && !i_cmd_full;
    assign accept     = i_in.valid && i_in.ready;
    assign fill_inc   = r_fill + CNT_W'(1);
    assign full_group = (fill_inc >= eff_size);
    assign complete   = full_group || i_in.list_end;

    assign o_wr.we    = accept;
    assign o_wr.bank  = r_bank;
    assign o_wr.idx   = IDX_MAX_W'(r_fill);
    assign o_wr_data  = SYMBOL_WIDTH'(i_in.symbol);

    assign o_cmd_push       = accept && complete;
    assign o_cmd.bank       = r_bank;
    assign o_cmd.count      = CNT_MAX_W'(fill_inc);
    assign o_cmd.reverse    = full_group;
    assign o_cmd.list_end   = i_in.list_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_bank <= 1'b0;
            r_busy <= 2'b00;
        end else begin
            if (i_release.valid) begin
                r_busy[i_release.bank] <= 1'b0;
            end
            if (accept) begin
                if (complete) begin
                    // The bank stays owned by the back end until it is drained.
                    r_fill         <= '0;
                    r_busy[r_bank] <= 1'b1;
                    r_bank         <= ~r_bank;
                end else begin
                    r_fill <= fill_inc;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/grs_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on grs_pkg for the command type and depth.
`default_nettype none

module grs_cmd_fifo
    import grs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output      logic o_full,
    input  wire logic i_pop,
    output      logic o_empty,
    output      t_cmd o_cmd
);

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int OCC_W = $clog2(CMD_DEPTH + 1);

    t_cmd             r_mem [CMD_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [OCC_W-1:0] r_occ;

    assign o_full  = (r_occ == OCC_W'(CMD_DEPTH));
    assign o_empty = (r_occ == '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_occ  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            r_occ <= r_occ + OCC_W'(i_push) - OCC_W'(i_pop);
        end
    end

endmodule

`default_nettype wire

// ===== design/grs_back.sv =====
// Back end: holds the two-bank buffer memory, reads each group out forward or
// reversed and presents the words through a two-entry output buffer.
// Depends on grs_pkg and grs_if.
`default_nettype none

module grs_back
    import grs_pkg::*;
#(
    parameter int MAX_GROUP    = DEF_MAX_GROUP,
    parameter int SYMBOL_WIDTH = DEF_SYMBOL_WIDTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_wr_ctl                 i_wr,
    input  wire logic [SYMBOL_WIDTH-1:0] i_wr_data,
    input  wire logic                    i_cmd_empty,
    input  wire t_cmd                    i_cmd,
    output      logic                    o_cmd_pop,
    output      t_release                o_release,
    grs_out_if.source                    o_out
);

    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int MEM_DEPTH = 2 << IDX_W;
    localparam int OB_DEPTH  = 2;
    localparam int OB_W      = 2;

    logic [SYMBOL_WIDTH-1:0] mem [MEM_DEPTH];

    t_back_state r_state;
    t_back_state n_state;

    logic             r_bank;
    logic [CNT_W-1:0] r_count;
    logic             r_reverse;
    logic             r_end;
    logic [CNT_W-1:0] r_idx;

    logic                    r_rd_vld;
    logic [SYMBOL_WIDTH-1:0] r_rd_data;
    logic                    r_rd_run;
    logic                    r_rd_done;

    logic [SYM_W-1:0] r_ob_sym  [OB_DEPTH];
    logic             r_ob_run  [OB_DEPTH];
    logic             r_ob_done [OB_DEPTH];
    logic             r_ob_wptr;
    logic             r_ob_rptr;
    logic [OB_W-1:0]  r_ob_occ;

    logic             out_pop;
    logic [OB_W-1:0]  occ_after;
    logic             issue_ok;
    logic             is_last;
    logic             rd_en;
    logic [CNT_W-1:0] rd_idx;
    logic [IDX_W:0]   rd_addr;

    assign out_pop   = o_out.valid && o_out.ready;
    // A read may start only if its word is sure to find a free output entry.
    assign occ_after = r_ob_occ + OB_W'(r_rd_vld) - OB_W'(out_pop);
    assign issue_ok  = (occ_after < OB_W'(OB_DEPTH));
    assign is_last   = (r_idx == r_count - CNT_W'(1));
    assign rd_idx    = r_reverse ? (r_count - CNT_W'(1) - r_idx) : r_idx;
    assign rd_addr   = {r_bank, rd_idx[IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd_pop       = 1'b0;
        rd_en           = 1'b0;
        o_release.valid = 1'b0;
        o_release.bank  = r_bank;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_state   = BK_RUN;
                end
            end
            BK_RUN: begin
                if (issue_ok) begin
                    rd_en = 1'b1;
                    if (is_last) begin
                        o_release.valid = 1'b1;
                        n_state         = BK_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[{i_wr.bank, i_wr.idx[IDX_W-1:0]}] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_run  <= is_last;
            r_rd_done <= is_last && r_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_bank    <= i_cmd.bank;
            r_count   <= CNT_W'(i_cmd.count);
            r_reverse <= i_cmd.reverse;
            r_end     <= i_cmd.list_end;
        end
        if (r_rd_vld) begin
            r_ob_sym[r_ob_wptr]  <= SYM_W'(r_rd_data);
            r_ob_run[r_ob_wptr]  <= r_rd_run;
            r_ob_done[r_ob_wptr] <= r_rd_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_ob_wptr <= 1'b0;
            r_ob_rptr <= 1'b0;
            r_ob_occ  <= '0;
        end else begin
            if (o_cmd_pop) begin
                r_idx <= '0;
            end else if (rd_en) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            r_rd_vld <= rd_en;
            if (r_rd_vld) begin
                r_ob_wptr <= ~r_ob_wptr;
            end
            if (out_pop) begin
                r_ob_rptr <= ~r_ob_rptr;
            end
            r_ob_occ <= occ_after;
        end
    end

    assign o_out.valid      = (r_ob_occ != '0);
    assign o_out.out_symbol = r_ob_sym[r_ob_rptr];
    assign o_out.run_end    = r_ob_run[r_ob_rptr];
    assign o_out.list_done  = r_ob_done[r_ob_rptr];

`ifndef NO_ASSERTIONS
    // The output buffer plus the read in flight never exceed its two entries.
    a_ob_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (OB_W'(r_ob_occ) + OB_W'(r_rd_vld)) <= OB_W'(OB_DEPTH))
        else $error("output buffer overrun");

    // A bank is released only while a group is being read out.
    a_release_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_release.valid |-> (r_state == BK_RUN))
        else $error("bank released outside readout");

    // The read that releases a bank delivers a word that closes its run.
    a_release_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_release.valid |=> (r_rd_vld && r_rd_run))
        else $error("release not on last word of group");

    // The end of the list is always also the end of a run.
    a_done_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.list_done) |-> o_out.run_end)
        else $error("list_done without run_end");
`endif

endmodule

`default_nettype wire

// ===== design/group_reverse_stream_top.sv =====
// Group reverse stream: input words are collected into groups of group_size
// symbols; a full group comes out in reverse order, and a list that ends
// short of a full group comes out in original order. The front end takes one
// word per cycle into a two-bank buffer, so one group fills while the other
// drains. The back end emits one word per cycle when the output is ready
// and pauses to load each command; input stalls only when both banks hold
// groups that are not yet fully read. Group size is written over APB at
// address 0. Depends on grs_pkg, grs_if, grs_front, grs_cmd_fifo and grs_back.
`default_nettype none

module group_reverse_stream_top
    import grs_pkg::*;
#(
    parameter int MAX_GROUP    = DEF_MAX_GROUP,
    parameter int SYMBOL_WIDTH = DEF_SYMBOL_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready,
    grs_in_if.sink                     i_in,
    grs_out_if.source                  o_out
);

    logic [GROUP_SIZE_W-1:0] r_group_size;

    logic                    cmd_push;
    logic                    cmd_pop;
    logic                    cmd_full;
    logic                    cmd_empty;
    t_cmd                    cmd_in;
    t_cmd                    cmd_out;
    t_wr_ctl                 wr_ctl;
    logic [SYMBOL_WIDTH-1:0] wr_data;
    t_release                release_bank;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_GROUP_SIZE) ? APB_DATA_W'(r_group_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GROUP_SIZE_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_GROUP_SIZE)) begin
            r_group_size <= pwdata[GROUP_SIZE_W-1:0];
        end
    end

    grs_front #(
        .MAX_GROUP    (MAX_GROUP),
        .SYMBOL_WIDTH (SYMBOL_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_group_size (r_group_size),
        .i_in         (i_in),
        .i_cmd_full   (cmd_full),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in),
        .o_wr         (wr_ctl),
        .o_wr_data    (wr_data),
        .i_release    (release_bank)
    );

    grs_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_out)
    );

    grs_back #(
        .MAX_GROUP    (MAX_GROUP),
        .SYMBOL_WIDTH (SYMBOL_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr_ctl),
        .i_wr_data   (wr_data),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_release   (release_bank),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== dv/grs_reorder_checker.sv =====
// Checker for the group reverse stream block: follows APB writes to the group
// size, predicts every output word from the accepted input words and compares.
// Depends on grs_pkg and the channel interfaces in grs_if.
`timescale 1ns / 1ps

module grs_reorder_checker
    import grs_pkg::*;
#(
    parameter int MAX_GROUP = DEF_MAX_GROUP
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic [APB_DATA_W-1:0] prdata,
    input  wire logic                  pready,
    grs_in_if                          i_in,
    grs_out_if                         o_out,
    output int                         o_mismatches,
    output int                         o_pending,
    output int                         o_words_checked
);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             run_end;
        logic             list_done;
    } t_out_word;

    t_out_word               expected_words[$];
    logic [SYM_W-1:0]        group_buf[MAX_GROUP];
    int unsigned             fill_cnt;
    logic [GROUP_SIZE_W-1:0] group_size_reg;

    initial begin
        o_mismatches    = 0;
        o_pending       = 0;
        o_words_checked = 0;
        fill_cnt        = 0;
        group_size_reg  = GROUP_SIZE_RESET;
    end

    function automatic int unsigned active_group_size(input logic [GROUP_SIZE_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_GROUP)
            return MAX_GROUP;
        return raw;
    endfunction

    // A full group leaves newest first; a list that ends short of a full group
    // leaves in arrival order.
    task automatic predict_reorder(input logic [SYM_W-1:0] sym, input logic last_in_list);
        int unsigned gsz;
        int unsigned n;
        int unsigned i;
        t_out_word   w;
        gsz = active_group_size(group_size_reg);
        if (fill_cnt < MAX_GROUP) begin
            group_buf[fill_cnt] = sym;
            fill_cnt++;
        end
        n = fill_cnt;
        if (n >= gsz || last_in_list) begin
            for (i = 0; i < n; i++) begin
                w.symbol    = (n >= gsz) ? group_buf[n - 1 - i] : group_buf[i];
                w.run_end   = (i + 1 == n);
                w.list_done = (i + 1 == n) && last_in_list;
                expected_words.push_back(w);
            end
            fill_cnt = 0;
        end
    endtask

    task automatic compare_word(input logic [SYM_W-1:0] sym, input logic run_end,
                                input logic list_done);
        t_out_word want;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected output word, expected none, got symbol %02h run_end %b list_done %b",
                     $time, sym, run_end, list_done);
            o_mismatches++;
        end else begin
            want = expected_words.pop_front();
            if (sym !== want.symbol) begin
                $display("%0t: out_symbol expected %02h got %02h", $time, want.symbol, sym);
                o_mismatches++;
            end
            if (run_end !== want.run_end) begin
                $display("%0t: run_end expected %b got %b", $time, want.run_end, run_end);
                o_mismatches++;
            end
            if (list_done !== want.list_done) begin
                $display("%0t: list_done expected %b got %b", $time, want.list_done, list_done);
                o_mismatches++;
            end
            o_words_checked++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_words.delete();
            fill_cnt       = 0;
            group_size_reg = GROUP_SIZE_RESET;
        end else begin
            if (psel && penable && pready && paddr == ADDR_GROUP_SIZE) begin
                if (pwrite) begin
                    group_size_reg = pwdata[GROUP_SIZE_W-1:0];
                end else if (prdata !== APB_DATA_W'(group_size_reg)) begin
                    $display("%0t: group_size read expected %0d got %0d",
                             $time, group_size_reg, prdata);
                    o_mismatches++;
                end
            end
            if (i_in.valid && i_in.ready)
                predict_reorder(i_in.symbol, i_in.list_end);
            if (o_out.valid && o_out.ready)
                compare_word(o_out.out_symbol, o_out.run_end, o_out.list_done);
        end
        o_pending = expected_words.size();
    end

endmodule

// ===== dv/group_reverse_stream_top_tb.sv =====
// Testbench top for the group reverse stream block: drives input words, the
// output ready and APB writes of the group size, and gives the verdict.
// Depends on grs_pkg, grs_if, the block and grs_reorder_checker.
`timescale 1ns / 1ps

module group_reverse_stream_top_tb;
    import grs_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_WORDS = 270;
    localparam int CYCLE_LIMIT  = 200000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    grs_in_if  in_ch ();
    grs_out_if out_ch ();

    int mismatches;
    int pending;
    int words_checked;
    int cycle_cnt     = 0;
    int words_sent    = 0;
    int lists_sent    = 0;
    int size_writes   = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int rx_hold_left  = 0;
    int rx_stall_left = 0;
    bit tx_idling     = 1'b0;
    bit rx_idling     = 1'b0;

    always #6 i_clk = ~i_clk;

    group_reverse_stream_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    grs_reorder_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in            (in_ch),
        .o_out           (out_ch),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_words_checked (words_checked)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles, %0d words still expected",
                     $time, cycle_cnt, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served  = hold_requests;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_stall_left > 0) begin
                rx_stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (rx_idling && $urandom_range(0, 99) < 30) begin
                rx_stall_left = idle_len() - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Each task starts and ends at a falling edge.
    task automatic send_word(input logic [SYM_W-1:0] sym, input logic ends);
        int gap;
        gap = (tx_idling && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        if (gap > 0) begin
            in_ch.valid    <= 1'b0;
            in_ch.symbol   <= SYM_W'($urandom_range(0, 255));
            in_ch.list_end <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.symbol   <= sym;
        in_ch.list_end <= ends;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        words_sent++;
        if (ends)
            lists_sent++;
    endtask

    task automatic send_run(input int len, input logic ends);
        int i;
        for (i = 0; i < len; i++)
            send_word(SYM_W'($urandom_range(0, 255)), ends && (i == len - 1));
    endtask

    task automatic stop_sending();
        in_ch.valid    <= 1'b0;
        in_ch.list_end <= 1'b0;
    endtask

    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_GROUP_SIZE;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Upper data bits are random; only the low five bits belong to the register.
    task automatic set_group_size(input int raw);
        logic [APB_DATA_W-1:0] data;
        data                     = $urandom();
        data[GROUP_SIZE_W-1:0]   = GROUP_SIZE_W'(raw);
        apb_access(1'b1, data);
        apb_access(1'b0, '0);
        size_writes++;
    endtask

    // A word that completes nothing leaves no expectation, so the block gets
    // some extra cycles after the last expected word before a register write.
    task automatic wait_idle();
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int raw;
        int gsz;
        int budget;
        int phase_words;
        int len;
        int phase;
        int first_random;

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.symbol   = '0;
        in_ch.list_end = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset value of the group size is read back before anything is written.
        apb_access(1'b0, '0);

        // Default size two: a full group on the list end, then a one-word list.
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'hA5, 1'b1);
        stop_sending();
        wait_idle();

        // Size zero acts as one.
        set_group_size(0);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b1);
        stop_sending();
        wait_idle();

        // Size above the buffer depth is clamped; the full group ends the list.
        set_group_size(31);
        send_run(16, 1'b1);
        stop_sending();
        wait_idle();

        // Size lowered below the pending count: the next word closes the group.
        set_group_size(5);
        send_run(3, 1'b0);
        stop_sending();
        wait_idle();
        set_group_size(2);
        send_word(8'h7E, 1'b0);
        stop_sending();
        wait_idle();

        // The fixed phases, including the hold-off, always run.
        first_random = words_sent;
        phase        = 0;
        while (phase < 5 || words_sent - first_random < RANDOM_WORDS) begin
            case (phase)
                0: raw = 16;
                1: raw = 31;
                2: raw = 1;
                3: raw = 0;
                4: raw = 4;
                default: begin
                    if ($urandom_range(0, 9) == 0)
                        raw = $urandom_range(0, 31);
                    else
                        raw = $urandom_range(1, 8);
                end
            endcase
            set_group_size(raw);
            gsz       = (raw == 0) ? 1 : ((raw > DEF_MAX_GROUP) ? DEF_MAX_GROUP : raw);
            tx_idling = ($urandom_range(0, 3) != 0);
            rx_idling = ($urandom_range(0, 3) != 0);
            budget    = $urandom_range(20, 40);
            if (phase == 4) begin
                // Output held off while the input keeps coming, so both banks fill.
                tx_idling = 1'b0;
                budget    = 64;
                hold_requests++;
            end
            phase_words = 0;
            while (phase_words < budget) begin
                len = $urandom_range(1, 3 * gsz);
                send_run(len, $urandom_range(0, 9) != 0);
                phase_words += len;
            end
            // Sometimes leave a partial group pending across the next size change.
            if (gsz > 1 && $urandom_range(0, 2) == 0)
                send_run($urandom_range(1, gsz - 1), 1'b0);
            stop_sending();
            wait_idle();
            phase++;
        end

        $display("Sent %0d words in %0d lists, %0d group-size writes, %0d words checked.",
                 words_sent, lists_sent, size_writes, words_checked);
        $display("Sizes 0, 1, 16 and 31 were used; a %0d-cycle output hold-off stalled the input.",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
